FILE: src/atrs_pkg.sv
// Package for the attention row softmax block: sizes, codes, the config struct,
// effective-size helpers and the exponential table built at elaboration.
// Depends on nothing; every other source file imports it.
package atrs_pkg;

    // Store sizes and element width
    localparam int MAX_SEQ        = 256;
    localparam int MAX_DIM        = 64;
    localparam int ELEM_W         = 16;
    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_N          = 1 << EXP_TABLE_BITS;

    localparam int SEQ_W  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_SEQ + 1);
    localparam int DCNT_W = $clog2(MAX_DIM + 1);
    localparam int MEM_AW = SEQ_W + DIM_W;

    // Datapath widths
    localparam int MAC_A_W     = 33;
    localparam int PROD_W      = MAC_A_W + ELEM_W;
    localparam int ACC_W       = PROD_W + SEQ_W;
    localparam int DOT_W       = 2 * ELEM_W + DIM_W;
    localparam int SCALE_W     = 16;
    localparam int SCORE_SHIFT = 24;
    localparam int SCORE_W     = DOT_W + SCALE_W - SCORE_SHIFT;
    localparam int T_W         = SCORE_W + 2;
    localparam int WGT_W       = 32;
    localparam int WSUM_W      = 31 + SEQ_W;
    localparam int NUM_W       = ACC_W;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = ELEM_W'((1 << (ELEM_W - 1)) - 1);
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = ELEM_W'(1 << (ELEM_W - 1));

    // Operation codes of an input transfer
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_SEQ_LEN     = 2'd0;
    localparam logic [1:0] REG_HEAD_DIM    = 2'd1;
    localparam logic [1:0] REG_CAUSAL      = 2'd2;
    localparam logic [1:0] REG_SCORE_SCALE = 2'd3;

    typedef struct packed {
        logic [8:0]  seq_len;
        logic [6:0]  head_dim;
        logic        causal;
        logic [15:0] score_scale;
    } atrs_cfg_t;

    typedef logic [WGT_W-1:0] exp_tab_t [EXP_N];

    // Effective number of rows: zero acts as one, large values clamp.
    function automatic logic [CNT_W-1:0] eff_len(input logic [8:0] v);
        logic [CNT_W-1:0] r;
        if (v == 9'd0) begin
            r = CNT_W'(1);
        end else if (int'(v) > MAX_SEQ) begin
            r = CNT_W'(MAX_SEQ);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    // Effective elements per row: zero acts as one, large values clamp.
    function automatic logic [DCNT_W-1:0] eff_dim(input logic [6:0] v);
        logic [DCNT_W-1:0] r;
        if (v == 7'd0) begin
            r = DCNT_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DCNT_W'(MAX_DIM);
        end else begin
            r = DCNT_W'(v);
        end
        return r;
    endfunction

    // Integer square root, rounded down.
    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = x_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Table of 2^(-k/EXP_N) in Q2.30, built by repeated multiplication.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t t;
        logic [63:0] r;
        r = 64'd1 << 29;
        for (int k = 0; k < EXP_TABLE_BITS; k++) begin
            r = isqrt64(r << 30);
        end
        t[0] = WGT_W'(1 << 30);
        for (int k = 1; k < EXP_N; k++) begin
            t[k] = WGT_W'((64'(t[k-1]) * r) >> 30);
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: src/atrs_mac.sv
// Shared multiply-accumulate unit: a registered product and a running sum.
// Depends on atrs_pkg for the operand and accumulator widths.
module atrs_mac (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic                              in_first,
    input  logic                              in_last,
    input  logic signed [atrs_pkg::MAC_A_W-1:0] in_a,
    input  logic signed [atrs_pkg::ELEM_W-1:0]  in_b,
    output logic                              res_valid,
    output logic signed [atrs_pkg::ACC_W-1:0]   res_acc
);
    import atrs_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_valid_reg;
    logic                     p_first_reg;
    logic                     p_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     res_valid_reg;

    // The sum restarts on the first term of each group.
    assign acc_next = (p_first_reg ? '0 : acc_reg) + ACC_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            p_valid_reg   <= in_valid;
            res_valid_reg <= p_valid_reg && p_last_reg;
        end
        prod_reg    <= in_a * in_b;
        p_first_reg <= in_first;
        p_last_reg  <= in_last;
        if (p_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_acc   = acc_reg;

endmodule

FILE: src/atrs_div.sv
// Restoring divider, one quotient bit per cycle, for the output normalization.
// Depends on atrs_pkg for the numerator and denominator widths.
module atrs_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [atrs_pkg::NUM_W-1:0]  num,
    input  logic [atrs_pkg::WSUM_W-1:0] den,
    output logic                        done,
    output logic [atrs_pkg::NUM_W-1:0]  quot
);
    import atrs_pkg::*;

    localparam int DIV_CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  numq_reg;
    logic [WSUM_W-1:0] den_reg;
    logic [WSUM_W-1:0] rem_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WSUM_W:0]   rem_sh;
    logic              fits;

    // One restoring step: shift in the next numerator bit and try to subtract.
    assign rem_sh = {rem_reg, numq_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= DIV_CW'(cnt_reg - 1'b1);
                if (cnt_reg == DIV_CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            numq_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            numq_reg <= {numq_reg[NUM_W-2:0], fits};
            rem_reg  <= fits ? WSUM_W'(rem_sh - {1'b0, den_reg}) : WSUM_W'(rem_sh);
        end
    end

    assign done = done_reg;
    assign quot = numq_reg;

endmodule

FILE: src/atrs_core.sv
// Attention datapath and sequencer: key/value/query/weight memories, the score,
// exponent and weighted-sum passes on the shared MAC, and the output register.
// Depends on atrs_pkg, atrs_mac and atrs_div.
module atrs_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  atrs_pkg::atrs_cfg_t         cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [7:0]                  s_row,
    input  logic [5:0]                  s_col,
    input  logic signed [15:0]          s_key_elem,
    input  logic signed [15:0]          s_value_elem,
    input  logic signed [15:0]          s_query_elem,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_out_elem,
    output logic [7:0]                  m_out_row,
    output logic [5:0]                  m_out_col,
    output logic                        m_row_done
);
    import atrs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCORE, ST_SC_DRAIN, ST_EXP, ST_EXP_DRAIN,
        ST_COLMAC, ST_COLWAIT, ST_DIVIDE, ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [7:0]          row_reg;
    logic [CNT_W-1:0]    lj_reg;
    logic [DCNT_W-1:0]   dlim_reg;
    logic [CNT_W-1:0]    ij_reg;
    logic [DCNT_W-1:0]   id_reg;
    logic [DCNT_W-1:0]   col_reg;
    logic [CNT_W-1:0]    wr_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic [WSUM_W-1:0]   wsum_reg;
    logic                div_start_reg;
    logic [NUM_W-1:0]    num_reg;
    logic                neg_reg;
    logic                m_valid_reg;
    logic signed [15:0]  m_elem_reg;
    logic [7:0]          m_row_reg;
    logic [5:0]          m_col_reg;
    logic                m_done_reg;

    // Memories
    logic [ELEM_W-1:0]   key_mem   [2**MEM_AW];
    logic [ELEM_W-1:0]   value_mem [2**MEM_AW];
    logic [ELEM_W-1:0]   q_mem     [MAX_DIM];
    logic [WGT_W-1:0]    w_mem     [MAX_SEQ];
    logic signed [ELEM_W-1:0] k_rd;
    logic signed [ELEM_W-1:0] v_rd;
    logic signed [ELEM_W-1:0] q_rd;
    logic [WGT_W-1:0]    w_rd;

    // Pipeline control
    logic                m1_v_reg, m1_first_reg, m1_last_reg;
    logic                e1_v_reg, ea_v_reg, eb_v_reg, ec_v_reg;
    logic                sc_v_reg;
    logic signed [DOT_W+SCALE_W:0] sc_prod_reg;
    logic [SCORE_W:0]    dd_reg;
    logic [T_W-1:0]      t_reg;
    logic [WGT_W-1:0]    rom_reg;
    logic                nbig_reg;
    logic [4:0]          nsh_reg;

    logic                in_acc;
    logic                ld_we;
    logic                q_we;
    logic                trigger;
    logic [CNT_W-1:0]    lj_new;
    logic [DCNT_W-1:0]   dlim_new;
    logic [MEM_AW-1:0]   ld_addr;
    logic [MEM_AW-1:0]   k_addr;
    logic [MEM_AW-1:0]   v_addr;
    logic                iss_v;
    logic                iss_first;
    logic                iss_last;
    logic                e_iss;
    logic                col_mode;
    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [ELEM_W-1:0]  mac_b;
    logic                mac_res_v;
    logic signed [ACC_W-1:0]   mac_acc;
    logic signed [SCORE_W-1:0] score_new;
    logic signed [SCORE_W-1:0] score_rd;
    logic [WGT_W-1:0]    weight_new;
    logic                w_we;
    logic [WGT_W-1:0]    w_wdata;
    logic [SCORE_W+17:0] t_prod;
    logic [NUM_W-1:0]    acc_mag;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic signed [15:0]  sat_elem;

    // Input transfer decode
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign ld_we    = in_acc && (s_operation == OP_LOAD) && (int'(s_row) < MAX_SEQ)
                      && (int'(s_col) < MAX_DIM);
    assign q_we     = in_acc && (s_operation == OP_QUERY) && (int'(s_col) < MAX_DIM);
    assign dlim_new = eff_dim(cfg.head_dim);
    assign trigger  = q_we && (DCNT_W'(s_col) == DCNT_W'(dlim_new - 1'b1));
    assign ld_addr  = {SEQ_W'(s_row), DIM_W'(s_col)};

    // Causal rows stop at the query row.
    always_comb begin
        lj_new = eff_len(cfg.seq_len);
        if (cfg.causal && (int'(s_row) + 1 < int'(lj_new))) begin
            lj_new = CNT_W'(int'(s_row) + 1);
        end
    end

    // Issue of memory reads for the MAC and exponent passes
    always_comb begin
        iss_v     = 1'b0;
        iss_first = 1'b0;
        iss_last  = 1'b0;
        e_iss     = 1'b0;
        case (state_reg)
            ST_SCORE: begin
                iss_v     = 1'b1;
                iss_first = (id_reg == '0);
                iss_last  = (id_reg == DCNT_W'(dlim_reg - 1'b1));
            end
            ST_COLMAC: begin
                iss_v     = 1'b1;
                iss_first = (ij_reg == '0);
                iss_last  = (ij_reg == CNT_W'(lj_reg - 1'b1));
            end
            ST_EXP: begin
                e_iss = 1'b1;
            end
            default: begin
                iss_v = 1'b0;
            end
        endcase
    end

    assign k_addr = {SEQ_W'(ij_reg), DIM_W'(id_reg)};
    assign v_addr = {SEQ_W'(ij_reg), DIM_W'(col_reg)};

    // Key and value stores share the load write.
    always_ff @(posedge aclk) begin
        if (ld_we) begin
            key_mem[ld_addr]   <= s_key_elem;
            value_mem[ld_addr] <= s_value_elem;
        end
        k_rd <= key_mem[k_addr];
        v_rd <= value_mem[v_addr];
    end

    // Query row buffer
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[DIM_W'(s_col)] <= s_query_elem;
        end
        q_rd <= q_mem[DIM_W'(id_reg)];
    end

    // Score and weight buffer: scores first, then overwritten by weights.
    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[SEQ_W'(wr_reg)] <= w_wdata;
        end
        w_rd <= w_mem[SEQ_W'(ij_reg)];
    end

    // Shared MAC operands
    assign col_mode = (state_reg == ST_COLMAC) || (state_reg == ST_COLWAIT);
    assign mac_a    = col_mode ? $signed({1'b0, w_rd}) : MAC_A_W'(q_rd);
    assign mac_b    = col_mode ? v_rd : k_rd;

    atrs_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (m1_v_reg),
        .in_first  (m1_first_reg),
        .in_last   (m1_last_reg),
        .in_a      (mac_a),
        .in_b      (mac_b),
        .res_valid (mac_res_v),
        .res_acc   (mac_acc)
    );

    // Score, exponent and buffer write data
    assign score_new  = SCORE_W'(sc_prod_reg >>> SCORE_SHIFT);
    assign score_rd   = SCORE_W'(w_rd);
    assign t_prod     = dd_reg * LOG2E_Q16;
    assign weight_new = nbig_reg ? '0 : (rom_reg >> nsh_reg);
    assign w_we       = sc_v_reg || ec_v_reg;
    assign w_wdata    = sc_v_reg ? WGT_W'(score_new) : weight_new;
    assign acc_mag    = (mac_acc < 0) ? NUM_W'(-mac_acc) : NUM_W'(mac_acc);

    atrs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_reg),
        .den     (wsum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Round-to-nearest quotient carries the sign and saturates.
    always_comb begin
        if (neg_reg) begin
            sat_elem = (div_quot > NUM_W'(1 << (ELEM_W - 1))) ? ELEM_MIN
                       : ELEM_W'(-div_quot);
        end else begin
            sat_elem = (div_quot > NUM_W'(ELEM_MAX)) ? ELEM_MAX : ELEM_W'(div_quot);
        end
    end

    // Datapath pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            e1_v_reg <= 1'b0;
            ea_v_reg <= 1'b0;
            eb_v_reg <= 1'b0;
            ec_v_reg <= 1'b0;
            sc_v_reg <= 1'b0;
        end else begin
            m1_v_reg <= iss_v;
            e1_v_reg <= e_iss;
            ea_v_reg <= e1_v_reg;
            eb_v_reg <= ea_v_reg;
            ec_v_reg <= eb_v_reg;
            sc_v_reg <= mac_res_v && !col_mode;
        end
        m1_first_reg <= iss_first;
        m1_last_reg  <= iss_last;
        sc_prod_reg  <= $signed(mac_acc[DOT_W-1:0]) * $signed({1'b0, cfg.score_scale});
        dd_reg       <= (SCORE_W+1)'(max_reg) - (SCORE_W+1)'(score_rd);
        t_reg        <= T_W'(t_prod >> 16);
        rom_reg      <= EXP_TAB[t_reg[15 -: EXP_TABLE_BITS]];
        nbig_reg     <= |t_reg[T_W-1:21];
        nsh_reg      <= t_reg[20:16];
    end

    // Sequencer, running max, weight sum and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            wsum_reg      <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            wr_reg        <= '0;
            ij_reg        <= '0;
            id_reg        <= '0;
            col_reg       <= '0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (sc_v_reg) begin
                wr_reg <= CNT_W'(wr_reg + 1'b1);
                if (wr_reg == '0 || score_new > max_reg) begin
                    max_reg <= score_new;
                end
            end
            if (ec_v_reg) begin
                wr_reg   <= CNT_W'(wr_reg + 1'b1);
                wsum_reg <= wsum_reg + WSUM_W'(weight_new);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (trigger) begin
                        row_reg   <= s_row;
                        lj_reg    <= lj_new;
                        dlim_reg  <= dlim_new;
                        ij_reg    <= '0;
                        id_reg    <= '0;
                        wr_reg    <= '0;
                        state_reg <= ST_SCORE;
                    end
                end
                ST_SCORE: begin
                    if (iss_last) begin
                        id_reg <= '0;
                        ij_reg <= CNT_W'(ij_reg + 1'b1);
                        if (ij_reg == CNT_W'(lj_reg - 1'b1)) begin
                            state_reg <= ST_SC_DRAIN;
                        end
                    end else begin
                        id_reg <= DCNT_W'(id_reg + 1'b1);
                    end
                end
                ST_SC_DRAIN: begin
                    if (wr_reg == lj_reg) begin
                        ij_reg    <= '0;
                        wr_reg    <= '0;
                        wsum_reg  <= '0;
                        state_reg <= ST_EXP;
                    end
                end
                ST_EXP: begin
                    ij_reg <= CNT_W'(ij_reg + 1'b1);
                    if (ij_reg == CNT_W'(lj_reg - 1'b1)) begin
                        state_reg <= ST_EXP_DRAIN;
                    end
                end
                ST_EXP_DRAIN: begin
                    if (wr_reg == lj_reg) begin
                        ij_reg    <= '0;
                        col_reg   <= '0;
                        state_reg <= ST_COLMAC;
                    end
                end
                ST_COLMAC: begin
                    ij_reg <= CNT_W'(ij_reg + 1'b1);
                    if (iss_last) begin
                        state_reg <= ST_COLWAIT;
                    end
                end
                ST_COLWAIT: begin
                    if (mac_res_v) begin
                        num_reg       <= acc_mag + NUM_W'(wsum_reg >> 1);
                        neg_reg       <= (mac_acc < 0);
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_elem_reg  <= sat_elem;
                        m_row_reg   <= row_reg;
                        m_col_reg   <= 6'(col_reg);
                        m_done_reg  <= (col_reg == DCNT_W'(dlim_reg - 1'b1));
                        if (col_reg == DCNT_W'(dlim_reg - 1'b1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            col_reg   <= DCNT_W'(col_reg + 1'b1);
                            ij_reg    <= '0;
                            state_reg <= ST_COLMAC;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_elem = m_elem_reg;
    assign m_out_row  = m_row_reg;
    assign m_out_col  = m_col_reg;
    assign m_row_done = m_done_reg;

endmodule

FILE: src/attention_row_softmax_top.sv
// Top level of the attention row softmax block: configuration registers on the
// register port and the attention core. Depends on atrs_pkg and atrs_core.
//
// Loads and query elements that do not complete a row are taken while the core is
// idle. The query element at the last effective column (head_dim-1, zero read as
// one, clamped to 64) starts a row of work on one shared multiply-accumulate unit:
// a score pass over L allowed key rows of D elements, an exponent pass over the L
// rows, then for each of the D output columns a weighted-sum pass over L rows, the
// MAC drain, the one-bit-per-cycle divider and the output hand-off. The input is
// not ready while a row is in work. The memories need no clearing pass after reset.
// A finished column waits in an output register, and the next column's work goes on
// meanwhile.
module attention_row_softmax_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [7:0]         s_row,
    input  logic [5:0]         s_col,
    input  logic signed [15:0] s_key_elem,
    input  logic signed [15:0] s_value_elem,
    input  logic signed [15:0] s_query_elem,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_elem,
    output logic [7:0]         m_out_row,
    output logic [5:0]         m_out_col,
    output logic               m_row_done
);
    import atrs_pkg::*;

    atrs_cfg_t cfg_reg;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seq_len     <= 9'd256;
            cfg_reg.head_dim    <= 7'd64;
            cfg_reg.causal      <= 1'b0;
            cfg_reg.score_scale <= 16'd8192;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SEQ_LEN:     cfg_reg.seq_len     <= pwdata[8:0];
                REG_HEAD_DIM:    cfg_reg.head_dim    <= pwdata[6:0];
                REG_CAUSAL:      cfg_reg.causal      <= pwdata[0];
                REG_SCORE_SCALE: cfg_reg.score_scale <= pwdata[15:0];
                default:         cfg_reg.causal      <= cfg_reg.causal;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_SEQ_LEN:     prdata = 32'(cfg_reg.seq_len);
            REG_HEAD_DIM:    prdata = 32'(cfg_reg.head_dim);
            REG_CAUSAL:      prdata = 32'(cfg_reg.causal);
            REG_SCORE_SCALE: prdata = 32'(cfg_reg.score_scale);
            default:         prdata = '0;
        endcase
    end

    atrs_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_key_elem   (s_key_elem),
        .s_value_elem (s_value_elem),
        .s_query_elem (s_query_elem),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_elem   (m_out_elem),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_row_done   (m_row_done)
    );

`ifndef NO_ASSERTIONS
    // The last column of a row carries the end-of-row mark.
    a_done_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_done |->
            (DCNT_W'(m_out_col) == DCNT_W'(eff_dim(cfg_reg.head_dim) - 1'b1)))
        else $error("row_done on a column other than the last");

    // No column beyond the row width is ever presented.
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (DCNT_W'(m_out_col) < eff_dim(cfg_reg.head_dim)))
        else $error("output column beyond head_dim");

    // A presented result that is not the end of the row means the block is still busy.
    a_busy_mid_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_row_done |-> !s_ready)
        else $error("input ready while a row is still in progress");
`endif

endmodule

FILE: tb/attention_row_softmax_top_tb.sv
// Self-checking testbench for attention_row_softmax_top: fills the key and value stores,
// sends query rows and compares every output column with a row predictor kept here.
// Depends on atrs_pkg and the attention_row_softmax_top RTL.
module attention_row_softmax_top_tb;
    import atrs_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     ITEM_GOAL   = 460;

    typedef struct {
        logic [15:0] elem;
        logic [7:0]  row;
        logic [5:0]  col;
        logic        done;
    } attn_out_t;

    // Predicts the output columns of each query row from its own copy of the stores.
    class attn_row_predictor;
        logic signed [15:0] key_mem [MAX_SEQ*MAX_DIM];
        logic signed [15:0] val_mem [MAX_SEQ*MAX_DIM];
        logic signed [15:0] qrow_buf [MAX_DIM];
        longint unsigned    exp_lut [EXP_N];
        logic [8:0]         seq_len_r;
        logic [6:0]         head_dim_r;
        logic               causal_r;
        logic [15:0]        scale_r;
        attn_out_t          pending_cols [$];
        int                 errors;

        function new();
            longint unsigned r;
            seq_len_r = 9'd256;
            head_dim_r = 7'd64;
            causal_r = 1'b0;
            scale_r = 16'd8192;
            errors = 0;
            r = 64'd1 << 29;
            for (int k = 0; k < EXP_TABLE_BITS; k++) begin
                r = root_floor(r << 30);
            end
            exp_lut[0] = 64'd1 << 30;
            for (int k = 1; k < EXP_N; k++) begin
                exp_lut[k] = (exp_lut[k-1] * r) >> 30;
            end
        endfunction

        // Largest r with r*r <= x, found bit by bit from the top.
        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= x) begin
                    r = trial;
                end
            end
            return r;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_SEQ_LEN:     seq_len_r = data[8:0];
                REG_HEAD_DIM:    head_dim_r = data[6:0];
                REG_CAUSAL:      causal_r = data[0];
                REG_SCORE_SCALE: scale_r = data[15:0];
                default: ;
            endcase
        endfunction

        function int rows_used();
            return (seq_len_r == 0) ? 1 : ((seq_len_r > MAX_SEQ) ? MAX_SEQ : int'(seq_len_r));
        endfunction

        function int dims_used();
            return (head_dim_r == 0) ? 1 : ((head_dim_r > MAX_DIM) ? MAX_DIM : int'(head_dim_r));
        endfunction

        // Called for every accepted input transfer.
        function void note_transfer(logic op, logic [7:0] row, logic [5:0] col,
                                    logic [15:0] k, logic [15:0] v, logic [15:0] q);
            int              nl;
            int              nd;
            longint          scores [MAX_SEQ];
            longint unsigned wgt [MAX_SEQ];
            longint          top;
            longint          dot;
            longint          acc;
            longint          res;
            longint unsigned wsum;
            longint unsigned diff;
            longint unsigned t;
            longint unsigned mag;
            attn_out_t       o;
            nl = rows_used();
            nd = dims_used();
            if (op == OP_LOAD) begin
                key_mem[int'(row)*MAX_DIM + int'(col)] = k;
                val_mem[int'(row)*MAX_DIM + int'(col)] = v;
                return;
            end
            qrow_buf[col] = q;
            if (int'(col) != nd - 1) begin
                return;
            end
            // Scaled scores and their maximum over the allowed key rows.
            top = 0;
            for (int j = 0; j < nl; j++) begin
                if (causal_r && j > int'(row)) continue;
                dot = 0;
                for (int d = 0; d < nd; d++) begin
                    dot += longint'(qrow_buf[d]) * longint'(key_mem[j*MAX_DIM + d]);
                end
                scores[j] = (dot * longint'({48'd0, scale_r})) >>> 24;
                if (j == 0 || scores[j] > top) top = scores[j];
            end
            // Softmax numerators from the power-of-two table.
            wsum = 0;
            for (int j = 0; j < nl; j++) begin
                wgt[j] = 0;
                if (causal_r && j > int'(row)) continue;
                diff = longint'(top - scores[j]);
                t = (diff * 64'd94548) >> 16;
                if ((t >> 16) < 32) begin
                    wgt[j] = exp_lut[(t & 64'hFFFF) >> (16 - EXP_TABLE_BITS)] >> (t >> 16);
                end
                wsum += wgt[j];
            end
            // Weighted value sums, rounded and saturated per column.
            for (int d = 0; d < nd; d++) begin
                acc = 0;
                for (int j = 0; j < nl; j++) begin
                    acc += longint'(wgt[j]) * longint'(val_mem[j*MAX_DIM + d]);
                end
                mag = (acc < 0) ? longint'(-acc) : longint'(acc);
                mag = (mag + wsum / 2) / wsum;
                if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
                res = (acc < 0) ? -longint'(mag) : longint'(mag);
                if (res > 32767) res = 32767;
                if (res < -32768) res = -32768;
                o.elem = res[15:0];
                o.row = row;
                o.col = d[5:0];
                o.done = (d == nd - 1);
                pending_cols.push_back(o);
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_output(logic [15:0] elem, logic [7:0] row, logic [5:0] col,
                                   logic done);
            attn_out_t e;
            if (pending_cols.size() == 0) begin
                $display("%0t: unexpected output elem=%h row=%0d col=%0d done=%0b",
                         $time, elem, row, col, done);
                errors++;
                return;
            end
            e = pending_cols.pop_front();
            if (elem !== e.elem) begin
                $display("%0t: out_elem expected %h actual %h", $time, e.elem, elem);
                errors++;
            end
            if (row !== e.row) begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
                errors++;
            end
            if (col !== e.col) begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
                errors++;
            end
            if (done !== e.done) begin
                $display("%0t: row_done expected %0b actual %0b", $time, e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic               s_operation;
    logic [7:0]         s_row;
    logic [5:0]         s_col;
    logic signed [15:0] s_key_elem;
    logic signed [15:0] s_value_elem;
    logic signed [15:0] s_query_elem;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_out_elem;
    logic [7:0]         m_out_row;
    logic [5:0]         m_out_col;
    logic               m_row_done;

    attn_row_predictor pred = new();
    longint            cycle_count;
    int                items_sent;
    int                stall_left;
    bit                calm;

    attention_row_softmax_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_row(s_row), .s_col(s_col), .s_key_elem(s_key_elem),
        .s_value_elem(s_value_elem), .s_query_elem(s_query_elem),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_elem(m_out_elem),
        .m_out_row(m_out_row), .m_out_col(m_out_col), .m_row_done(m_row_done)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Mostly no gap, otherwise short gaps and now and then a long one; none at all in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side: check each transfer and stall at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                pred.check_output(m_out_elem, m_out_row, m_out_col, m_row_done);
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                stall_left <= pick_gap();
                m_ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pred.write_reg(idx, data);
    endtask

    // One input transfer after a random gap; valid stays up when no gap follows.
    task automatic send(logic op, logic [7:0] row, logic [5:0] col,
                        logic [15:0] k, logic [15:0] v, logic [15:0] q);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_row <= row;
        s_col <= col;
        s_key_elem <= k;
        s_value_elem <= v;
        s_query_elem <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred.note_transfer(op, row, col, k, v, q);
        items_sent++;
    endtask

    task automatic send_load(logic [7:0] row, logic [5:0] col);
        send(OP_LOAD, row, col, pick_elem(), pick_elem(), 16'($urandom()));
    endtask

    task automatic send_query(logic [7:0] row, logic [5:0] col, logic [15:0] q);
        send(OP_QUERY, row, col, 16'($urandom()), 16'($urandom()), q);
    endtask

    // Drain all pending columns plus a margin for work that produces no output.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pred.pending_cols.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // One configuration, the key rows it reads, then a few query rows.
    task automatic run_phase(int sl, int hd, bit causal_on, int sc, int key_rows, int nrows);
        int nl;
        int nd;
        int part;
        logic [7:0] qr;
        wait_idle();
        reg_write(REG_SEQ_LEN, sl);
        reg_write(REG_HEAD_DIM, hd);
        reg_write(REG_CAUSAL, causal_on);
        reg_write(REG_SCORE_SCALE, sc);
        calm = ($urandom_range(0, 3) == 0);
        nl = pred.rows_used();
        nd = pred.dims_used();
        if (key_rows > nl) key_rows = nl;
        for (int j = 0; j < key_rows; j++) begin
            for (int d = 0; d < nd; d++) begin
                send_load(j[7:0], d[5:0]);
                if ($urandom_range(0, 9) == 0) send_load(8'($urandom()), 6'($urandom()));
            end
        end
        for (int n = 0; n < nrows; n++) begin
            qr = (key_rows >= nl) ? 8'($urandom()) : 8'($urandom_range(0, key_rows - 1));
            // An abandoned partial row now and then; the full row rewrites it.
            if (nd > 1 && $urandom_range(0, 5) == 0) begin
                part = $urandom_range(1, nd - 1);
                for (int d = 0; d < part; d++) send_query(qr, d[5:0], pick_elem());
            end
            for (int d = 0; d < nd - 1; d++) begin
                send_query(qr, d[5:0], pick_elem());
                if ($urandom_range(0, 7) == 0) send_load(8'($urandom()), 6'($urandom()));
            end
            if (nd < MAX_DIM && $urandom_range(0, 2) == 0) begin
                send_query(qr, 6'($urandom_range(nd, MAX_DIM - 1)), pick_elem());
            end
            send_query(qr, 6'(nd - 1), pick_elem());
        end
    endtask

    initial begin
        int sc;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_operation = OP_LOAD;
        s_row = '0;
        s_col = '0;
        s_key_elem = '0;
        s_value_elem = '0;
        s_query_elem = '0;
        cycle_count = 0;
        items_sent = 0;
        calm = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one-element rows, extreme elements, rows past seq_len.
        reg_write(REG_SEQ_LEN, 2);
        reg_write(REG_HEAD_DIM, 0);
        reg_write(REG_CAUSAL, 0);
        reg_write(REG_SCORE_SCALE, 65535);
        send(OP_LOAD, 8'd0, 6'd0, 16'h7FFF, 16'h8000, 16'h0000);
        send(OP_LOAD, 8'd1, 6'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_query(8'd0, 6'd0, 16'h7FFF);
        send_query(8'd255, 6'd0, 16'h8000);
        send_query(8'd7, 6'd0, 16'h0000);
        send_query(8'd3, 6'd5, 16'h1234);
        send_query(8'd3, 6'd0, 16'h0001);
        send(OP_LOAD, 8'd255, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
        reg_write(REG_SEQ_LEN, 0);
        reg_write(REG_CAUSAL, 1);
        reg_write(REG_SCORE_SCALE, 0);
        send_query(8'd0, 6'd0, 16'h8000);
        send_query(8'd200, 6'd0, 16'h7FFF);
        wait_idle();
        reg_write(REG_SEQ_LEN, 2) ;
        send_query(8'd0, 6'd63, 16'h5555);
        send_query(8'd0, 6'd0, 16'h2AAA);

        // Widest setting: causal keeps the rows read to the two loaded ones.
        run_phase(511, 127, 1'b1, 8192, 2, 2);

        // Random phases of small sizes.
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 3))
                0: sc = 0;
                1: sc = 65535;
                2: sc = $urandom_range(8192, 40000);
                default: sc = $urandom_range(0, 65535);
            endcase
            run_phase($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 1), sc,
                      MAX_SEQ, $urandom_range(2, 6));
        end

        wait_idle();
        if (pred.errors == 0 && pred.pending_cols.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
